@@ src/ppl_pkg.sv @@
// shared types and constants for the positional pair list
// depends on nothing; ppl_ctrl and the top level import it

package ppl_pkg;

    // list geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // operation codes carried in the op field
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_NOKEY = 2'd3
    } ppl_status_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic [3:0]         position;
    } ppl_req_t;

    typedef struct packed {
        ppl_status_t        status;
        logic signed [31:0] out_key;
        logic signed [31:0] out_value;
        logic [4:0]         count;
    } ppl_rsp_t;

    // one stored pair, as held in the entry memory
    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
    } ppl_entry_t;

    localparam int ENTRY_W = $bits(ppl_entry_t);

    // memory access issued by the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        ppl_entry_t       wdata;
        logic [IDX_W-1:0] raddr;
    } ppl_ram_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UP,
        S_PUT,
        S_DOWN,
        S_SCAN,
        S_READ
    } ppl_state_t;

endpackage

@@ src/ppl_ram.sv @@
// generic single-write, single-read memory with registered read data
// self-contained, no package needed

module ppl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/ppl_ctrl.sv @@
// sequencer of the pair list: decodes one operation, walks the entry memory
// for shifts and key search, keeps the entry count; uses ppl_pkg

module ppl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ppl_pkg::ppl_req_t     req,
    output logic                  idle,
    output logic                  res_valid,
    output ppl_pkg::ppl_rsp_t     res,
    output ppl_pkg::ppl_ram_cmd_t ram_cmd,
    input  ppl_pkg::ppl_entry_t   ram_rdata
);

    import ppl_pkg::*;

    ppl_state_t       state_reg, state_next;
    ppl_req_t         req_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             full;
    logic             pos_bad;
    logic             empty;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] last_idx;
    logic             key_hit;
    ppl_entry_t       new_entry;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pos_bad   = (CNT_W'(req_reg.position) >= count_reg);
    assign pos_idx   = IDX_W'(req_reg.position);
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign key_hit   = (ram_rdata.key == req_reg.key);
    assign new_entry = '{key: req_reg.key, value: req_reg.value};
    assign idle      = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (req_reg.op)
                    OP_INSERT: state_next = (full || pos_bad) ? S_IDLE : S_UP;
                    OP_REMOVE: state_next = (pos_bad || pos_idx == last_idx) ? S_IDLE : S_DOWN;
                    OP_UPDATE: state_next = empty ? S_IDLE : S_SCAN;
                    OP_READ:   state_next = pos_bad ? S_IDLE : S_READ;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_UP:     state_next = (idx_reg == pos_idx) ? S_PUT : S_UP;
            S_PUT:    state_next = S_IDLE;
            S_DOWN:   state_next = (idx_reg == last_idx) ? S_IDLE : S_DOWN;
            S_SCAN:   state_next = (key_hit || idx_reg == last_idx) ? S_IDLE : S_SCAN;
            S_READ:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory commands, result and datapath updates
    always_comb
    begin
        ram_cmd.we     = 1'b0;
        ram_cmd.waddr  = idx_reg;
        ram_cmd.wdata  = ram_rdata;
        ram_cmd.raddr  = idx_reg;
        res_valid      = 1'b0;
        res.status     = STAT_OK;
        res.out_key    = '0;
        res.out_value  = '0;
        idx_next       = idx_reg;
        count_next     = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_DECODE:
            begin
                unique case (req_reg.op)
                    OP_APPEND:
                    begin
                        res_valid = 1'b1;
                        if (full)
                        begin
                            res.status = STAT_FULL;
                        end
                        else
                        begin
                            ram_cmd.we    = 1'b1;
                            ram_cmd.waddr = IDX_W'(count_reg);
                            ram_cmd.wdata = new_entry;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    OP_INSERT:
                    begin
                        if (full)
                        begin
                            res_valid  = 1'b1;
                            res.status = STAT_FULL;
                        end
                        else if (pos_bad)
                        begin
                            res_valid  = 1'b1;
                            res.status = STAT_RANGE;
                        end
                        else
                        begin
                            // start moving from the tail
                            ram_cmd.raddr = last_idx;
                            idx_next      = last_idx;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (pos_bad)
                        begin
                            res_valid  = 1'b1;
                            res.status = STAT_RANGE;
                        end
                        else if (pos_idx == last_idx)
                        begin
                            // removing the tail needs no move
                            res_valid  = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            ram_cmd.raddr = pos_idx + IDX_W'(1);
                            idx_next      = pos_idx + IDX_W'(1);
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (empty)
                        begin
                            res_valid  = 1'b1;
                            res.status = STAT_NOKEY;
                        end
                        else
                        begin
                            ram_cmd.raddr = '0;
                            idx_next      = '0;
                        end
                    end
                    OP_READ:
                    begin
                        if (pos_bad)
                        begin
                            res_valid  = 1'b1;
                            res.status = STAT_RANGE;
                        end
                        else
                        begin
                            ram_cmd.raddr = pos_idx;
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b1;
                    end
                endcase
            end
            S_UP:
            begin
                // entry idx moves to idx+1, fetch the one below meanwhile
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = idx_reg + IDX_W'(1);
                if (idx_reg != pos_idx)
                begin
                    ram_cmd.raddr = idx_reg - IDX_W'(1);
                    idx_next      = idx_reg - IDX_W'(1);
                end
            end
            S_PUT:
            begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = pos_idx;
                ram_cmd.wdata = new_entry;
                count_next    = count_reg + CNT_W'(1);
                res_valid     = 1'b1;
            end
            S_DOWN:
            begin
                // entry idx moves to idx-1, fetch the one above meanwhile
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = idx_reg - IDX_W'(1);
                if (idx_reg == last_idx)
                begin
                    count_next = count_reg - CNT_W'(1);
                    res_valid  = 1'b1;
                end
                else
                begin
                    ram_cmd.raddr = idx_reg + IDX_W'(1);
                    idx_next      = idx_reg + IDX_W'(1);
                end
            end
            S_SCAN:
            begin
                if (key_hit)
                begin
                    // stored key equals the searched key, so rewrite the whole pair
                    ram_cmd.we    = 1'b1;
                    ram_cmd.wdata = new_entry;
                    res_valid     = 1'b1;
                end
                else if (idx_reg == last_idx)
                begin
                    res_valid  = 1'b1;
                    res.status = STAT_NOKEY;
                end
                else
                begin
                    ram_cmd.raddr = idx_reg + IDX_W'(1);
                    idx_next      = idx_reg + IDX_W'(1);
                end
            end
            S_READ:
            begin
                res_valid     = 1'b1;
                res.out_key   = ram_rdata.key;
                res.out_value = ram_rdata.value;
            end
            default:
            begin
            end
        endcase

        res.count = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && idle)
        begin
            req_reg <= req;
        end
    end

endmodule

@@ src/positional_pair_list_top.sv @@
// top level of the positional pair list: request intake, sequencer,
// entry memory and a two-slot response buffer; uses ppl_pkg, ppl_ram, ppl_ctrl

// A list of up to DEPTH (16) key/value pairs kept packed from position 0.
// Request channel req_valid/req_stall/req carries one operation per
// transaction: append, insert at position, remove at position, update by
// key, read at position. Every request gives exactly one response
// transaction on rsp_valid/rsp_stall/rsp with status, read pair and count.
// A request is taken when the sequencer is idle and the response buffer has
// a free slot; the sequencer works on one request at a time.
// Steps per request, from intake until the sequencer is idle again:
//   append, unknown op, any rejected op: decode only
//   read: decode, then the read of the pair at the position
//   insert at p: decode, entries tail..p move up one, new pair written at p
//   remove at p: decode, entries p+1..tail move down one; tail: no move
//   update: decode, scan from index 0 until the key matches or the list ends
// The entry memory has a single read and a single write port, so moved or
// searched entries are handled one entry at a time.
// The first response is visible at the earliest once decoded and buffered.
// Reset empties the list; memory contents are not cleared and are never
// read before being written. A stalled receiver keeps the response in the
// buffer; one more request is still taken, after that req_stall holds.

module positional_pair_list_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ppl_pkg::ppl_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ppl_pkg::ppl_rsp_t rsp
);

    import ppl_pkg::*;

    logic         ctrl_idle;
    logic         ctrl_res_valid;
    ppl_rsp_t     ctrl_res;
    ppl_ram_cmd_t ram_cmd;
    ppl_entry_t   ram_rdata;
    logic         req_accept;
    logic         rsp_pop;

    // response buffer, two slots
    ppl_rsp_t   buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    // take a request only with the sequencer free and room for its response
    assign req_stall  = !ctrl_idle || (fill_reg == 2'd2);
    assign req_accept = req_valid && !req_stall;

    assign rsp_valid  = (fill_reg != 2'd0);
    assign rsp        = buf_reg[rd_ptr_reg];
    assign rsp_pop    = rsp_valid && !rsp_stall;

    ppl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_accept),
        .req       (req),
        .idle      (ctrl_idle),
        .res_valid (ctrl_res_valid),
        .res       (ctrl_res),
        .ram_cmd   (ram_cmd),
        .ram_rdata (ram_rdata)
    );

    // pairs stored side by side in one word; update rewrites the matched key
    // unchanged, so one write port serves every operation
    ppl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .raddr (ram_cmd.raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ ctrl_res_valid;
        rd_ptr_next = rd_ptr_reg ^ rsp_pop;
        fill_next   = fill_reg + {1'b0, ctrl_res_valid} - {1'b0, rsp_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_res_valid)
        begin
            buf_reg[wr_ptr_reg] <= ctrl_res;
        end
    end

    // a response never lands in a full buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_res_valid |-> (fill_reg != 2'd2 || rsp_pop))
    else $error("response pushed into full buffer");

    // an accepted request always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> !ctrl_idle)
    else $error("sequencer did not start on accepted request");

    // the memory is only written while an operation is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_cmd.we |-> !ctrl_idle)
    else $error("memory write while idle");

    // the reported count never exceeds the list depth
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.count <= 5'(DEPTH)))
    else $error("count beyond list depth");

endmodule
